[rtl/erv_pkg.sv]
// ----------------------------------------------------------------------------
// erv_pkg: Euler rebase vector rotator package
// Widths, constants, arctangent table and shared types.
// ----------------------------------------------------------------------------
package erv_pkg;

    localparam int CORDIC_STEPS  = 16;
    localparam int FRACTION_BITS = 16;

    localparam int IO_W    = 18;
    localparam int ANG_W   = 17;
    localparam int VEC_W   = 20;
    localparam int CS_W    = FRACTION_BITS + 2;
    localparam int PROD_W  = VEC_W + CS_W;
    localparam int NUM_ANG = 6;
    localparam int IDX_W   = 3;
    localparam int RED_W   = ANG_W + 1;
    localparam int CQ      = 30;
    localparam int CX_W    = 34;
    localparam int RAD_W   = 48;
    localparam int STEP_W  = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    localparam int RAD_Q40     = 191900981;
    localparam int CORDIC_GAIN = 652032874;
    localparam int OUT_MAX     = 131071;
    localparam int OUT_MIN     = -131072;
    localparam int FULL_TURN   = 36000;
    localparam int HALF_TURN   = 18000;
    localparam int QUART_TURN  = 9000;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_REDUCE,
        CS_FOLD,
        CS_RAD,
        CS_ITER,
        CS_DONE
    } t_cs_state;

    typedef struct packed {
        logic                    we;
        logic signed [CS_W-1:0]  cos;
        logic signed [CS_W-1:0]  sin;
    } t_cs_load;

    typedef struct packed {
        logic [NUM_ANG-1:0]      we;
        logic signed [CS_W-1:0]  cos;
        logic signed [CS_W-1:0]  sin;
    } t_cs_wr;

    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000008;
            5'd28: v = 32'h00000004;
            5'd29: v = 32'h00000002;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

[rtl/euler_rebase_vector_rotator_core.sv]
// ----------------------------------------------------------------------------
// euler_rebase_vector_rotator_core: Euler rebase vector rotator
// Undoes the old Euler rotation (z, y, x) and applies the new one (x, y, z)
// to each 3D vector item, through a row of six rotation cells.
//
//   channel   dir  handshake                        payload
//   vec_in    in   i_vec_in_valid / o_vec_in_ready  i_vec_in_x/y/z
//   vec_out   out  o_vec_out_valid/ i_vec_out_ready o_vec_out_x/y/z
//   cfg       in   i_cfg_valid / o_cfg_ready        i_cfg_index, i_cfg_data
//
// One item per cycle when not stalled; two register stages per cell.
// Each angle write reruns the CORDIC for its cell, during which no item is
// taken. After reset all six pairs are built in turn.
// A stall at the output holds the whole row of cells.
// ----------------------------------------------------------------------------
module euler_rebase_vector_rotator_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [erv_pkg::IDX_W-1:0]          i_cfg_index,
    input  logic signed [erv_pkg::ANG_W-1:0]   i_cfg_data,
    input  logic                               i_vec_in_valid,
    output logic                               o_vec_in_ready,
    input  logic signed [erv_pkg::IO_W-1:0]    i_vec_in_x,
    input  logic signed [erv_pkg::IO_W-1:0]    i_vec_in_y,
    input  logic signed [erv_pkg::IO_W-1:0]    i_vec_in_z,
    output logic                               o_vec_out_valid,
    input  logic                               i_vec_out_ready,
    output logic signed [erv_pkg::IO_W-1:0]    o_vec_out_x,
    output logic signed [erv_pkg::IO_W-1:0]    o_vec_out_y,
    output logic signed [erv_pkg::IO_W-1:0]    o_vec_out_z
);
    localparam int N = erv_pkg::NUM_ANG;
    localparam int VW = erv_pkg::VEC_W;

    erv_pkg::t_cs_wr   cs_wr;
    erv_pkg::t_cs_load cs_ld [N];
    logic              cs_ready, adv;
    logic                   vld [N+1];
    logic signed [VW-1:0]   vx [N+1];
    logic signed [VW-1:0]   vy [N+1];
    logic signed [VW-1:0]   vz [N+1];

    erv_cs_gen u_gen (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cs_wr     (cs_wr),
        .o_cs_ready  (cs_ready)
    );

    assign adv            = !vld[N] || i_vec_out_ready;
    assign o_vec_in_ready = adv && cs_ready;
    assign vld[0] = i_vec_in_valid && cs_ready;
    assign vx[0]  = VW'(i_vec_in_x);
    assign vy[0]  = VW'(i_vec_in_y);
    assign vz[0]  = VW'(i_vec_in_z);

    always_comb begin
        for (int k = 0; k < N; k++) begin
            cs_ld[k].we  = cs_wr.we[k];
            cs_ld[k].cos = cs_wr.cos;
            cs_ld[k].sin = cs_wr.sin;
        end
    end

    // undo z: (x, y)
    erv_cell u_c0 (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv), .i_cs(cs_ld[0]),
        .i_vld(vld[0]), .i_a(vx[0]), .i_b(vy[0]), .i_p(vz[0]),
        .o_vld(vld[1]), .o_a(vx[1]), .o_b(vy[1]), .o_p(vz[1]));
    // undo y: (z, x)
    erv_cell u_c1 (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv), .i_cs(cs_ld[1]),
        .i_vld(vld[1]), .i_a(vz[1]), .i_b(vx[1]), .i_p(vy[1]),
        .o_vld(vld[2]), .o_a(vz[2]), .o_b(vx[2]), .o_p(vy[2]));
    // undo x: (y, z)
    erv_cell u_c2 (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv), .i_cs(cs_ld[2]),
        .i_vld(vld[2]), .i_a(vy[2]), .i_b(vz[2]), .i_p(vx[2]),
        .o_vld(vld[3]), .o_a(vy[3]), .o_b(vz[3]), .o_p(vx[3]));
    // apply x: (y, z)
    erv_cell u_c3 (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv), .i_cs(cs_ld[3]),
        .i_vld(vld[3]), .i_a(vy[3]), .i_b(vz[3]), .i_p(vx[3]),
        .o_vld(vld[4]), .o_a(vy[4]), .o_b(vz[4]), .o_p(vx[4]));
    // apply y: (z, x)
    erv_cell u_c4 (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv), .i_cs(cs_ld[4]),
        .i_vld(vld[4]), .i_a(vz[4]), .i_b(vx[4]), .i_p(vy[4]),
        .o_vld(vld[5]), .o_a(vz[5]), .o_b(vx[5]), .o_p(vy[5]));
    // apply z: (x, y)
    erv_cell u_c5 (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv), .i_cs(cs_ld[5]),
        .i_vld(vld[5]), .i_a(vx[5]), .i_b(vy[5]), .i_p(vz[5]),
        .o_vld(vld[6]), .o_a(vx[6]), .o_b(vy[6]), .o_p(vz[6]));

    assign o_vec_out_valid = vld[N];

    always_comb begin
        priority if (vx[N] > VW'(erv_pkg::OUT_MAX)) begin
            o_vec_out_x = erv_pkg::IO_W'(erv_pkg::OUT_MAX);
        end else if (vx[N] < VW'(erv_pkg::OUT_MIN)) begin
            o_vec_out_x = erv_pkg::IO_W'(erv_pkg::OUT_MIN);
        end else begin
            o_vec_out_x = erv_pkg::IO_W'(vx[N]);
        end
        priority if (vy[N] > VW'(erv_pkg::OUT_MAX)) begin
            o_vec_out_y = erv_pkg::IO_W'(erv_pkg::OUT_MAX);
        end else if (vy[N] < VW'(erv_pkg::OUT_MIN)) begin
            o_vec_out_y = erv_pkg::IO_W'(erv_pkg::OUT_MIN);
        end else begin
            o_vec_out_y = erv_pkg::IO_W'(vy[N]);
        end
        priority if (vz[N] > VW'(erv_pkg::OUT_MAX)) begin
            o_vec_out_z = erv_pkg::IO_W'(erv_pkg::OUT_MAX);
        end else if (vz[N] < VW'(erv_pkg::OUT_MIN)) begin
            o_vec_out_z = erv_pkg::IO_W'(erv_pkg::OUT_MIN);
        end else begin
            o_vec_out_z = erv_pkg::IO_W'(vz[N]);
        end
    end

endmodule

[rtl/erv_cs_gen.sv]
// ----------------------------------------------------------------------------
// erv_cs_gen: angle registers and cosine/sine generator
// Holds the six angles, and for each changed angle reduces it, converts it to
// radians and runs an iterative CORDIC, then loads the result into its cell.
// ----------------------------------------------------------------------------
module erv_cs_gen (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [erv_pkg::IDX_W-1:0]         i_cfg_index,
    input  logic signed [erv_pkg::ANG_W-1:0]  i_cfg_data,
    output erv_pkg::t_cs_wr                   o_cs_wr,
    output logic                              o_cs_ready
);
    localparam int S = erv_pkg::CQ - erv_pkg::FRACTION_BITS;
    localparam int RW = erv_pkg::CX_W + 2;

    erv_pkg::t_cs_state r_state, n_state;

    logic signed [erv_pkg::ANG_W-1:0]  r_ang [erv_pkg::NUM_ANG];
    logic [erv_pkg::NUM_ANG-1:0]       r_pend, n_pend, clr, set;
    logic [erv_pkg::IDX_W-1:0]         r_job, n_job, pick;
    logic signed [erv_pkg::RED_W-1:0]  r_r, n_r;
    logic signed [erv_pkg::RED_W-1:0]  sel_ang [erv_pkg::NUM_ANG];
    logic                              r_flip, n_flip;
    logic signed [erv_pkg::CX_W-1:0]   r_x, n_x, r_y, n_y, r_z, n_z;
    logic [erv_pkg::STEP_W-1:0]        r_i, n_i;
    logic signed [erv_pkg::RAD_W-1:0]  rad_p;
    logic signed [erv_pkg::CX_W-1:0]   atn;
    logic signed [RW-1:0]              rx, ry;
    logic signed [erv_pkg::CS_W-1:0]   c_q, s_q;
    logic                              cfg_we;
    logic [erv_pkg::NUM_ANG-1:0]       done_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we = i_cfg_valid && (i_cfg_index < erv_pkg::IDX_W'(erv_pkg::NUM_ANG));

    // cells 0..2 undo z, y, x; cells 3..5 apply x, y, z
    always_comb begin
        sel_ang[0] = -erv_pkg::RED_W'(r_ang[2]);
        sel_ang[1] = -erv_pkg::RED_W'(r_ang[1]);
        sel_ang[2] = -erv_pkg::RED_W'(r_ang[0]);
        sel_ang[3] = erv_pkg::RED_W'(r_ang[3]);
        sel_ang[4] = erv_pkg::RED_W'(r_ang[4]);
        sel_ang[5] = erv_pkg::RED_W'(r_ang[5]);
    end

    always_comb begin
        set = '0;
        if (cfg_we) begin
            if (i_cfg_index < erv_pkg::IDX_W'(3)) begin
                set[erv_pkg::IDX_W'(2) - i_cfg_index] = 1'b1;
            end else begin
                set[i_cfg_index] = 1'b1;
            end
        end
    end

    always_comb begin
        pick = '0;
        for (int k = erv_pkg::NUM_ANG - 1; k >= 0; k--) begin
            if (r_pend[k]) begin
                pick = erv_pkg::IDX_W'(k);
            end
        end
    end

    assign rad_p = erv_pkg::RAD_W'(r_r) * erv_pkg::RAD_W'(erv_pkg::RAD_Q40);
    assign atn   = erv_pkg::CX_W'(erv_pkg::atan_q30(5'(r_i)));
    assign rx    = ((RW'(r_x) <<< 1) + (RW'(1) <<< S)) >>> (S + 1);
    assign ry    = ((RW'(r_y) <<< 1) + (RW'(1) <<< S)) >>> (S + 1);
    assign c_q   = r_flip ? -erv_pkg::CS_W'(rx) : erv_pkg::CS_W'(rx);
    assign s_q   = r_flip ? -erv_pkg::CS_W'(ry) : erv_pkg::CS_W'(ry);
    assign done_we = erv_pkg::NUM_ANG'(1) << r_job;

    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        n_r     = r_r;
        n_flip  = r_flip;
        n_x     = r_x;
        n_y     = r_y;
        n_z     = r_z;
        n_i     = r_i;
        clr     = '0;
        o_cs_wr.we  = '0;
        o_cs_wr.cos = c_q;
        o_cs_wr.sin = s_q;
        unique case (r_state)
            erv_pkg::CS_IDLE: begin
                if (r_pend != '0) begin
                    n_job     = pick;
                    clr[pick] = 1'b1;
                    n_r       = sel_ang[pick];
                    n_flip    = 1'b0;
                    n_state   = erv_pkg::CS_REDUCE;
                end
            end
            erv_pkg::CS_REDUCE: begin
                if (r_r >= erv_pkg::RED_W'(erv_pkg::HALF_TURN)) begin
                    n_r = r_r - erv_pkg::RED_W'(erv_pkg::FULL_TURN);
                end else if (r_r < -erv_pkg::RED_W'(erv_pkg::HALF_TURN)) begin
                    n_r = r_r + erv_pkg::RED_W'(erv_pkg::FULL_TURN);
                end else begin
                    n_state = erv_pkg::CS_FOLD;
                end
            end
            erv_pkg::CS_FOLD: begin
                if (r_r > erv_pkg::RED_W'(erv_pkg::QUART_TURN)) begin
                    n_r    = r_r - erv_pkg::RED_W'(erv_pkg::HALF_TURN);
                    n_flip = 1'b1;
                end else if (r_r < -erv_pkg::RED_W'(erv_pkg::QUART_TURN)) begin
                    n_r    = r_r + erv_pkg::RED_W'(erv_pkg::HALF_TURN);
                    n_flip = 1'b1;
                end
                n_state = erv_pkg::CS_RAD;
            end
            erv_pkg::CS_RAD: begin
                n_z = erv_pkg::CX_W'(((rad_p <<< 1) + erv_pkg::RAD_W'(1024)) >>> 11);
                n_x = erv_pkg::CX_W'(erv_pkg::CORDIC_GAIN);
                n_y = '0;
                n_i = '0;
                n_state = erv_pkg::CS_ITER;
            end
            erv_pkg::CS_ITER: begin
                if (r_z >= 0) begin
                    n_x = r_x - (r_y >>> r_i);
                    n_y = r_y + (r_x >>> r_i);
                    n_z = r_z - atn;
                end else begin
                    n_x = r_x + (r_y >>> r_i);
                    n_y = r_y - (r_x >>> r_i);
                    n_z = r_z + atn;
                end
                n_i = r_i + 1'b1;
                if (r_i == erv_pkg::STEP_W'(erv_pkg::CORDIC_STEPS - 1)) begin
                    n_state = erv_pkg::CS_DONE;
                end
            end
            erv_pkg::CS_DONE: begin
                o_cs_wr.we = done_we;
                n_state    = erv_pkg::CS_IDLE;
            end
            default: n_state = erv_pkg::CS_IDLE;
        endcase
    end

    assign n_pend     = (r_pend & ~clr) | set;
    assign o_cs_ready = (r_state == erv_pkg::CS_IDLE) && (r_pend == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= erv_pkg::CS_IDLE;
            r_pend  <= '1;
            for (int k = 0; k < erv_pkg::NUM_ANG; k++) begin
                r_ang[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            if (cfg_we) begin
                r_ang[i_cfg_index] <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_job  <= n_job;
        r_r    <= n_r;
        r_flip <= n_flip;
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_i    <= n_i;
    end

endmodule

[rtl/erv_cell.sv]
// ----------------------------------------------------------------------------
// erv_cell: one plane-rotation cell
// Holds one cosine/sine pair and rotates components a and b of each passing
// vector; the third component rides along. Two register stages.
// ----------------------------------------------------------------------------
module erv_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  erv_pkg::t_cs_load                  i_cs,
    input  logic                               i_vld,
    input  logic signed [erv_pkg::VEC_W-1:0]   i_a,
    input  logic signed [erv_pkg::VEC_W-1:0]   i_b,
    input  logic signed [erv_pkg::VEC_W-1:0]   i_p,
    output logic                               o_vld,
    output logic signed [erv_pkg::VEC_W-1:0]   o_a,
    output logic signed [erv_pkg::VEC_W-1:0]   o_b,
    output logic signed [erv_pkg::VEC_W-1:0]   o_p
);
    localparam int PW = erv_pkg::PROD_W;
    localparam int F  = erv_pkg::FRACTION_BITS;

    logic signed [erv_pkg::CS_W-1:0]  r_cos, r_sin;
    logic signed [PW-1:0]             r_ac, r_bs, r_as, r_bc;
    logic signed [erv_pkg::VEC_W-1:0] r_p1, r_a, r_b, r_p2;
    logic                             r_vld1, r_vld2;
    logic signed [PW+1:0]             sum_a, sum_b, rnd_a, rnd_b;

    assign sum_a = (PW+2)'(r_ac) - (PW+2)'(r_bs);
    assign sum_b = (PW+2)'(r_as) + (PW+2)'(r_bc);
    assign rnd_a = ((sum_a <<< 1) + ((PW+2)'(1) <<< F)) >>> (F + 1);
    assign rnd_b = ((sum_b <<< 1) + ((PW+2)'(1) <<< F)) >>> (F + 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cs.we) begin
            r_cos <= i_cs.cos;
            r_sin <= i_cs.sin;
        end
        if (i_en) begin
            r_ac <= PW'(i_a) * PW'(r_cos);
            r_bs <= PW'(i_b) * PW'(r_sin);
            r_as <= PW'(i_a) * PW'(r_sin);
            r_bc <= PW'(i_b) * PW'(r_cos);
            r_p1 <= i_p;
            r_a  <= erv_pkg::VEC_W'(rnd_a);
            r_b  <= erv_pkg::VEC_W'(rnd_b);
            r_p2 <= r_p1;
        end
    end

    assign o_vld = r_vld2;
    assign o_a   = r_a;
    assign o_b   = r_b;
    assign o_p   = r_p2;

endmodule
